/* rtl/pllm_pkg.sv */
package pllm_pkg;

   // Pool geometry. Slot numbers on the ports are always 8 bits wide; the
   // link store is addressed by the slot number reduced modulo the pool depth.
   localparam int POOL_DEPTH = 256;
   localparam int SLOT_W     = 8;
   localparam int NUM_SLOTS  = 2 ** SLOT_W;
   localparam int IDX_W      = $clog2(POOL_DEPTH);
   localparam int COUNT_W    = 9;
   localparam int CSR_ADDR_W = 1;

   typedef logic [SLOT_W-1:0]  slot_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type COUNT_MAX       = '1;
   localparam slot_type  LAST_SLOT_RESET = slot_type'(NUM_SLOTS - 1);

   // Request codes.
   typedef enum logic [1:0] {
      REQ_INIT = 2'd0,
      REQ_ADD  = 2'd1,
      REQ_POP  = 2'd2,
      REQ_NOP  = 2'd3
   } req_kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FIRST_SLOT = 1'b0,
      CSR_LAST_SLOT  = 1'b1
   } csr_index_type;

   // Decoded request handed to the list engine.
   typedef struct packed {
      req_kind_type kind;
      logic         use_head;
      idx_type      target;
   } req_fields_type;

   // Result of one transaction.
   typedef struct packed {
      status_type status;
      slot_type   slot;
      count_type  count;
      slot_type   head;
      logic       head_valid;
   } rsp_fields_type;

   // One link memory port: a write port and a read address.
   typedef struct packed {
      logic    we;
      idx_type waddr;
      idx_type wdata;
      idx_type raddr;
   } link_port_type;

   // Slot number to link store index, built at elaboration.
   typedef logic [NUM_SLOTS-1:0][IDX_W-1:0] slot_map_type;

   function automatic slot_map_type build_slot_map();
      slot_map_type map;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         map[i] = idx_type'(i % POOL_DEPTH);
      end
      return map;
   endfunction

   localparam slot_map_type SLOT_MAP = build_slot_map();

   function automatic idx_type slot_to_idx(slot_type s);
      return SLOT_MAP[s];
   endfunction

   // Indexes never exceed the 8-bit slot range, so resizing is lossless.
   function automatic slot_type idx_to_slot(idx_type i);
      return slot_type'(i);
   endfunction

endpackage

/* rtl/pllm_ram.sv */
module pllm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read (old data on a same-address write).
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rdata = rd_data_ff;

endmodule

/* rtl/pllm_engine.sv */
module pllm_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  pllm_pkg::req_fields_type req,
   input  pllm_pkg::idx_type        first_idx,
   input  pllm_pkg::idx_type        last_idx,
   input  logic                     out_free,
   input  pllm_pkg::idx_type        prev_rdata,
   input  pllm_pkg::idx_type        next_rdata,
   output logic                     ready,
   output logic                     done,
   output pllm_pkg::rsp_fields_type rsp,
   output pllm_pkg::link_port_type  prev_port,
   output pllm_pkg::link_port_type  next_port
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_INIT = 6'b000010,
      ST_DET  = 6'b000100,
      ST_INS1 = 6'b001000,
      ST_INS2 = 6'b010000,
      ST_RESP = 6'b100000
   } fsm_state_type;

   fsm_state_type          state_ff, state_in;
   pllm_pkg::idx_type      used_head_ff, used_head_in;
   logic                   used_valid_ff, used_valid_in;
   pllm_pkg::idx_type      free_head_ff, free_head_in;
   logic                   free_valid_ff, free_valid_in;
   pllm_pkg::count_type    used_count_ff, used_count_in;

   // Per-transaction working registers.
   pllm_pkg::idx_type      node_ff, node_in;
   pllm_pkg::idx_type      ref_ff, ref_in;
   logic                   ref_valid_ff, ref_valid_in;
   logic                   from_free_ff, from_free_in;
   logic                   make_head_ff, make_head_in;
   logic                   fwd_ff, fwd_in;
   pllm_pkg::idx_type      fwd_prev_ff, fwd_prev_in;
   pllm_pkg::idx_type      cur_ff, cur_in;
   pllm_pkg::status_type   status_ff, status_in;
   pllm_pkg::slot_type     slot_ff, slot_in;

   logic                   solo;
   logic                   ins_finish;
   pllm_pkg::idx_type      ref_prev;

   // In the detach step the read data hold the node's own links.
   assign solo     = (next_rdata == node_ff);
   // The predecessor of the insert point, forwarded past the detach write.
   assign ref_prev = fwd_ff ? fwd_prev_ff : prev_rdata;
   assign ready    = (state_ff == ST_IDLE);

   // Sequencer: accept/read, init chain or detach and insert (one or two write steps), respond.
   always_comb begin
      state_in      = state_ff;
      used_head_in  = used_head_ff;
      used_valid_in = used_valid_ff;
      free_head_in  = free_head_ff;
      free_valid_in = free_valid_ff;
      used_count_in = used_count_ff;
      node_in       = node_ff;
      ref_in        = ref_ff;
      ref_valid_in  = ref_valid_ff;
      from_free_in  = from_free_ff;
      make_head_in  = make_head_ff;
      fwd_in        = fwd_ff;
      fwd_prev_in   = fwd_prev_ff;
      cur_in        = cur_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      prev_port     = '0;
      next_port     = '0;
      prev_port.raddr = ref_ff;
      next_port.raddr = node_ff;
      ins_finish    = 1'b0;
      done          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req.kind)
                  pllm_pkg::REQ_INIT: begin
                     used_head_in  = '0;
                     used_valid_in = 1'b0;
                     used_count_in = '0;
                     status_in     = pllm_pkg::STATUS_OK;
                     slot_in       = '0;
                     if (last_idx >= first_idx) begin
                        free_head_in  = first_idx;
                        free_valid_in = 1'b1;
                        cur_in        = first_idx;
                        state_in      = ST_INIT;
                     end else begin
                        free_head_in  = '0;
                        free_valid_in = 1'b0;
                        state_in      = ST_RESP;
                     end
                  end
                  pllm_pkg::REQ_ADD: begin
                     if (!free_valid_ff) begin
                        status_in = pllm_pkg::STATUS_NO_FREE;
                        slot_in   = '0;
                        state_in  = ST_RESP;
                     end else begin
                        node_in      = free_head_ff;
                        from_free_in = 1'b1;
                        make_head_in = req.use_head || !used_valid_ff;
                        if (req.use_head || !used_valid_ff) begin
                           ref_in       = used_head_ff;
                           ref_valid_in = used_valid_ff;
                        end else begin
                           ref_in       = req.target;
                           ref_valid_in = 1'b1;
                        end
                        if (used_count_ff != pllm_pkg::COUNT_MAX) begin
                           used_count_in = used_count_ff + 1'b1;
                        end
                        status_in       = pllm_pkg::STATUS_OK;
                        slot_in         = pllm_pkg::idx_to_slot(free_head_ff);
                        prev_port.raddr = free_head_ff;
                        next_port.raddr = free_head_ff;
                        state_in        = ST_DET;
                     end
                  end
                  pllm_pkg::REQ_POP: begin
                     if (!used_valid_ff) begin
                        status_in = pllm_pkg::STATUS_EMPTY;
                        slot_in   = '0;
                        state_in  = ST_RESP;
                     end else begin
                        node_in      = req.target;
                        from_free_in = 1'b0;
                        make_head_in = 1'b0;
                        ref_in       = free_head_ff;
                        ref_valid_in = free_valid_ff;
                        if (used_count_ff != '0) begin
                           used_count_in = used_count_ff - 1'b1;
                        end
                        status_in       = pllm_pkg::STATUS_OK;
                        slot_in         = pllm_pkg::idx_to_slot(req.target);
                        prev_port.raddr = req.target;
                        next_port.raddr = req.target;
                        state_in        = ST_DET;
                     end
                  end
                  pllm_pkg::REQ_NOP: begin
                     status_in = pllm_pkg::STATUS_OK;
                     slot_in   = '0;
                     state_in  = ST_RESP;
                  end
               endcase
            end
         end

         // Chain one slot of the configured range per cycle into a ring.
         ST_INIT: begin
            prev_port.we    = 1'b1;
            prev_port.waddr = cur_ff;
            prev_port.wdata = (cur_ff == first_idx) ? last_idx
                                                    : pllm_pkg::idx_type'(cur_ff - 1'b1);
            next_port.we    = 1'b1;
            next_port.waddr = cur_ff;
            next_port.wdata = (cur_ff == last_idx) ? first_idx
                                                   : pllm_pkg::idx_type'(cur_ff + 1'b1);
            if (cur_ff == last_idx) begin
               state_in = ST_RESP;
            end else begin
               cur_in = pllm_pkg::idx_type'(cur_ff + 1'b1);
            end
         end

         // Unlink the node from its ring and read the insert point's prev link.
         ST_DET: begin
            if (!solo) begin
               next_port.we    = 1'b1;
               next_port.waddr = prev_rdata;
               next_port.wdata = next_rdata;
               prev_port.we    = 1'b1;
               prev_port.waddr = next_rdata;
               prev_port.wdata = prev_rdata;
            end
            if (from_free_ff) begin
               if (solo) begin
                  free_valid_in = 1'b0;
                  free_head_in  = '0;
               end else if (free_head_ff == node_ff) begin
                  free_head_in = next_rdata;
               end
            end else begin
               if (solo) begin
                  used_valid_in = 1'b0;
                  used_head_in  = '0;
               end else if (used_head_ff == node_ff) begin
                  used_head_in = next_rdata;
               end
            end
            // The read of prev[ref] sees old data if it hits this cycle's write.
            fwd_in      = !solo && (ref_ff == next_rdata);
            fwd_prev_in = prev_rdata;
            state_in    = ST_INS1;
         end

         // First insert step, or the self-link into an empty ring.
         ST_INS1: begin
            if (ref_valid_ff) begin
               next_port.we    = 1'b1;
               next_port.waddr = ref_prev;
               next_port.wdata = node_ff;
               prev_port.we    = 1'b1;
               prev_port.waddr = node_ff;
               prev_port.wdata = ref_prev;
               state_in        = ST_INS2;
            end else begin
               next_port.we    = 1'b1;
               next_port.waddr = node_ff;
               next_port.wdata = node_ff;
               prev_port.we    = 1'b1;
               prev_port.waddr = node_ff;
               prev_port.wdata = node_ff;
               ins_finish      = out_free;
            end
         end

         // Second insert step; repeated harmlessly while the response waits.
         ST_INS2: begin
            next_port.we    = 1'b1;
            next_port.waddr = node_ff;
            next_port.wdata = ref_ff;
            prev_port.we    = 1'b1;
            prev_port.waddr = ref_ff;
            prev_port.wdata = node_ff;
            ins_finish      = out_free;
         end

         ST_RESP: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Head update of the ring the node was inserted into.
      if (ins_finish) begin
         done     = 1'b1;
         state_in = ST_IDLE;
         if (from_free_ff) begin
            if (make_head_ff) begin
               used_head_in  = node_ff;
               used_valid_in = 1'b1;
            end
         end else begin
            free_head_in  = node_ff;
            free_valid_in = 1'b1;
         end
      end
   end

   // Response fields reflect the list state after the transaction.
   always_comb begin
      rsp.status     = status_ff;
      rsp.slot       = slot_ff;
      rsp.count      = used_count_ff;
      rsp.head       = used_valid_in ? pllm_pkg::idx_to_slot(used_head_in) : '0;
      rsp.head_valid = used_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_head_ff  <= '0;
         used_valid_ff <= 1'b0;
         free_head_ff  <= '0;
         free_valid_ff <= 1'b0;
         used_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         used_head_ff  <= used_head_in;
         used_valid_ff <= used_valid_in;
         free_head_ff  <= free_head_in;
         free_valid_ff <= free_valid_in;
         used_count_ff <= used_count_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      ref_ff       <= ref_in;
      ref_valid_ff <= ref_valid_in;
      from_free_ff <= from_free_in;
      make_head_ff <= make_head_in;
      fwd_ff       <= fwd_in;
      fwd_prev_ff  <= fwd_prev_in;
      cur_ff       <= cur_in;
      status_ff    <= status_in;
      slot_ff      <= slot_in;
   end

`ifndef NO_ASSERTIONS
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(prev_port.we || next_port.we))
      else $error("link memory written while idle");

   a_done_needs_room: assert property (@(posedge clock) disable iff (reset)
      done |-> out_free)
      else $error("response produced while output register is full");

   a_used_head_cleared: assert property (@(posedge clock) disable iff (reset)
      !used_valid_ff |-> (used_head_ff == '0))
      else $error("used head nonzero on an empty used list");

   a_free_head_cleared: assert property (@(posedge clock) disable iff (reset)
      !free_valid_ff |-> (free_head_ff == '0))
      else $error("free head nonzero on an empty free list");

   a_add_enters_detach: assert property (@(posedge clock) disable iff (reset)
      (start && ready && (req.kind == pllm_pkg::REQ_ADD) && free_valid_ff)
      |=> (state_ff == ST_DET))
      else $error("add with a free slot did not start the detach step");
`endif

endmodule

/* rtl/pooled_linked_list_manager.sv */
// Channel   Ports                         Transaction
// --------  ----------------------------  ------------------------------------
// request   req_valid / req_ready         req_type, req_use_head, req_target_slot
// response  rsp_valid / rsp_ready         rsp_status, rsp_slot, rsp_count,
//                                         rsp_head, rsp_head_valid
// config    csr_we                        csr_addr selects, csr_wdata is written
//
// One transaction is in flight; the link memories set the pace. Add and pop go through
// detach and two insert steps to the response, one when the receiving list is empty.
// Init chains one slot per cycle into a ring, or responds directly when last_slot is
// below first_slot; errors and no-ops respond directly. A new request is accepted while
// the previous response waits in the output register; a stalled response holds the
// engine in its last step. Reset clears heads and counts; links are unknown until init.
module pooled_linked_list_manager (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_type,
   input  logic                               req_use_head,
   input  logic [pllm_pkg::SLOT_W-1:0]        req_target_slot,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic [pllm_pkg::SLOT_W-1:0]        rsp_slot,
   output logic [pllm_pkg::COUNT_W-1:0]       rsp_count,
   output logic [pllm_pkg::SLOT_W-1:0]        rsp_head,
   output logic                               rsp_head_valid,
   input  logic                               csr_we,
   input  logic [pllm_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [pllm_pkg::SLOT_W-1:0]        csr_wdata
);

   pllm_pkg::slot_type        first_slot_ff, first_slot_in;
   pllm_pkg::slot_type        last_slot_ff, last_slot_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   pllm_pkg::rsp_fields_type  rsp_data_ff;

   pllm_pkg::req_fields_type  req_fields;
   pllm_pkg::rsp_fields_type  eng_rsp;
   pllm_pkg::link_port_type   prev_port;
   pllm_pkg::link_port_type   next_port;
   pllm_pkg::idx_type         prev_rdata;
   pllm_pkg::idx_type         next_rdata;
   logic                      eng_ready;
   logic                      eng_done;
   logic                      out_free;
   logic                      start;

   // Configuration register writes.
   always_comb begin
      first_slot_in = first_slot_ff;
      last_slot_in  = last_slot_ff;
      if (csr_we) begin
         unique case (csr_addr)
            pllm_pkg::CSR_FIRST_SLOT: first_slot_in = csr_wdata;
            pllm_pkg::CSR_LAST_SLOT:  last_slot_in  = csr_wdata;
            default:                  first_slot_in = first_slot_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_slot_ff <= '0;
         last_slot_ff  <= pllm_pkg::LAST_SLOT_RESET;
      end else begin
         first_slot_ff <= first_slot_in;
         last_slot_ff  <= last_slot_in;
      end
   end

   // Request decode.
   assign req_ready           = eng_ready;
   assign start               = req_valid && eng_ready;
   assign req_fields.kind     = pllm_pkg::req_kind_type'(req_type);
   assign req_fields.use_head = req_use_head;
   assign req_fields.target   = pllm_pkg::slot_to_idx(req_target_slot);

   // Output register: frees when empty or being taken this cycle.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = eng_done || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_done) begin
         rsp_data_ff <= eng_rsp;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_slot       = rsp_data_ff.slot;
   assign rsp_count      = rsp_data_ff.count;
   assign rsp_head       = rsp_data_ff.head;
   assign rsp_head_valid = rsp_data_ff.head_valid;

   // List sequencer.
   pllm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_fields),
      .first_idx  (pllm_pkg::slot_to_idx(first_slot_ff)),
      .last_idx   (pllm_pkg::slot_to_idx(last_slot_ff)),
      .out_free   (out_free),
      .prev_rdata (prev_rdata),
      .next_rdata (next_rdata),
      .ready      (eng_ready),
      .done       (eng_done),
      .rsp        (eng_rsp),
      .prev_port  (prev_port),
      .next_port  (next_port)
   );

   // Previous-link store.
   pllm_ram #(
      .WIDTH (pllm_pkg::IDX_W),
      .DEPTH (pllm_pkg::POOL_DEPTH)
   ) u_prev_ram (
      .clock (clock),
      .we    (prev_port.we),
      .waddr (prev_port.waddr),
      .wdata (prev_port.wdata),
      .raddr (prev_port.raddr),
      .rdata (prev_rdata)
   );

   // Next-link store.
   pllm_ram #(
      .WIDTH (pllm_pkg::IDX_W),
      .DEPTH (pllm_pkg::POOL_DEPTH)
   ) u_next_ram (
      .clock (clock),
      .we    (next_port.we),
      .waddr (next_port.waddr),
      .wdata (next_port.wdata),
      .raddr (next_port.raddr),
      .rdata (next_rdata)
   );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import pllm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // One request transaction as the bench builds it.
   typedef struct packed {
      req_kind_type kind;
      logic         use_head;
      slot_type     target;
   } request_t;

   // Shadow of the slot pool: predicts each response and checks the block against it.
   class list_scoreboard;
      slot_type       prev_ln[POOL_DEPTH];
      slot_type       next_ln[POOL_DEPTH];
      slot_type       used_head;
      logic           used_valid;
      slot_type       free_head;
      logic           free_valid;
      count_type      used_count;
      slot_type       first_slot;
      slot_type       last_slot;
      slot_type       members[$];
      rsp_fields_type expected_q[$];
      int             errors;

      function new();
         foreach (prev_ln[i]) begin
            prev_ln[i] = '0;
            next_ln[i] = '0;
         end
         used_head  = '0;
         used_valid = 1'b0;
         free_head  = '0;
         free_valid = 1'b0;
         used_count = '0;
         first_slot = '0;
         last_slot  = LAST_SLOT_RESET;
         errors     = 0;
      endfunction

      function int ix(slot_type s);
         return int'(s) % POOL_DEPTH;
      endfunction

      function void write_reg(csr_index_type idx, slot_type value);
         if (idx == CSR_FIRST_SLOT) first_slot = value;
         else last_slot = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Walk the used ring from its head; bounded, since stray pops can break the ring.
      function void collect_used();
         slot_type s;
         members.delete();
         if (!used_valid) return;
         s = used_head;
         for (int k = 0; k < POOL_DEPTH; k++) begin
            members.push_back(s);
            s = next_ln[ix(s)];
            if (s == used_head) break;
         end
      endfunction

      // Take slot n out of the free ring or the used ring.
      function void unlink(logic on_free, slot_type n);
         slot_type p;
         slot_type q;
         p = prev_ln[ix(n)];
         q = next_ln[ix(n)];
         if (ix(q) == ix(n)) begin
            if (on_free) free_valid = 1'b0;
            else used_valid = 1'b0;
         end else begin
            next_ln[ix(p)] = q;
            prev_ln[ix(q)] = p;
            if (on_free) begin
               if (free_head == n) free_head = q;
            end else if (used_head == n) begin
               used_head = q;
            end
         end
      endfunction

      // Put slot n just ahead of slot r, or make it a ring of its own.
      function void link_before(slot_type r, logic r_valid, slot_type n);
         slot_type rp;
         if (!r_valid) begin
            prev_ln[ix(n)] = n;
            next_ln[ix(n)] = n;
         end else begin
            rp = prev_ln[ix(r)];
            next_ln[ix(rp)] = n;
            prev_ln[ix(n)]  = rp;
            next_ln[ix(n)]  = r;
            prev_ln[ix(r)]  = n;
         end
      endfunction

      // Apply one accepted request and queue the response it must produce.
      function void note_request(request_t rq);
         rsp_fields_type e;
         slot_type       n;
         int             lo;
         int             hi;
         e = '0;
         e.status = STATUS_OK;
         case (rq.kind)
            REQ_INIT: begin
               lo = ix(first_slot);
               hi = ix(last_slot);
               used_head  = '0;
               used_valid = 1'b0;
               used_count = '0;
               free_valid = (hi >= lo);
               free_head  = free_valid ? slot_type'(lo) : '0;
               if (free_valid) begin
                  for (int s = lo; s <= hi; s++) begin
                     prev_ln[s] = slot_type'((s == lo) ? hi : s - 1);
                     next_ln[s] = slot_type'((s == hi) ? lo : s + 1);
                  end
               end
            end
            REQ_ADD: begin
               if (!free_valid) begin
                  e.status = STATUS_NO_FREE;
               end else begin
                  n = free_head;
                  unlink(1'b1, n);
                  if (!free_valid) free_head = '0;
                  if (rq.use_head || !used_valid) begin
                     link_before(used_head, used_valid, n);
                     used_head  = n;
                     used_valid = 1'b1;
                  end else begin
                     link_before(rq.target, 1'b1, n);
                  end
                  if (used_count != COUNT_MAX) used_count++;
                  e.slot = n;
               end
            end
            REQ_POP: begin
               if (!used_valid) begin
                  e.status = STATUS_EMPTY;
               end else begin
                  if (used_count != '0) used_count--;
                  unlink(1'b0, rq.target);
                  if (!used_valid) used_head = '0;
                  link_before(free_head, free_valid, rq.target);
                  free_head  = rq.target;
                  free_valid = 1'b1;
                  e.slot = rq.target;
               end
            end
            default: ;
         endcase
         e.count      = used_count;
         e.head       = used_valid ? used_head : '0;
         e.head_valid = used_valid;
         expected_q.push_back(e);
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got) begin
            errors++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      // Compare one accepted response with the oldest prediction.
      function void check_response(rsp_fields_type got);
         rsp_fields_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t response with nothing expected: status %0d slot %0d count %0d",
                     $time, got.status, got.slot, got.count);
            return;
         end
         want = expected_q.pop_front();
         check_field("rsp_status", int'(want.status), int'(got.status));
         check_field("rsp_slot", int'(want.slot), int'(got.slot));
         check_field("rsp_count", int'(want.count), int'(got.count));
         check_field("rsp_head", int'(want.head), int'(got.head));
         check_field("rsp_head_valid", int'(want.head_valid), int'(got.head_valid));
      endfunction
   endclass

   logic          clock;
   logic          reset = 1'b1;
   logic          req_valid;
   logic          req_ready;
   logic [1:0]    req_type;
   logic          req_use_head;
   slot_type      req_target_slot;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [1:0]    rsp_status;
   slot_type      rsp_slot;
   count_type     rsp_count;
   slot_type      rsp_head;
   logic          rsp_head_valid;
   logic          csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   slot_type      csr_wdata;

   list_scoreboard board;
   bit             idle_on;
   int             hold_request;
   int             cycles;

   pooled_linked_list_manager DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_use_head    (req_use_head),
      .req_target_slot (req_target_slot),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_count       (rsp_count),
      .rsp_head        (rsp_head),
      .rsp_head_valid  (rsp_head_valid),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb NOT OK");
      $finish;
   end

   // Response side: checks every transaction and stalls in bursts or one long hold.
   initial begin : response_sink
      int             stall_left;
      int             hold_left;
      rsp_fields_type got;
      stall_left = 0;
      hold_left  = 0;
      rsp_ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            got.status     = status_type'(rsp_status);
            got.slot       = rsp_slot;
            got.count      = rsp_count;
            got.head       = rsp_head;
            got.head_valid = rsp_head_valid;
            board.check_response(got);
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one request, with an optional idle burst first, and wait for acceptance.
   task automatic send_request(req_kind_type kind, logic use_head, slot_type target);
      request_t rq;
      rq.kind     = kind;
      rq.use_head = use_head;
      rq.target   = target;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_use_head    <= use_head;
      req_target_slot <= target;
      do @(posedge clock); while (!req_ready);
      board.note_request(rq);
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both range registers on back-to-back cycles; only called when idle.
   task automatic write_range(slot_type lo_slot, slot_type hi_slot);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_FIRST_SLOT;
      csr_wdata <= lo_slot;
      @(posedge clock);
      csr_addr  <= CSR_LAST_SLOT;
      csr_wdata <= hi_slot;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.write_reg(CSR_FIRST_SLOT, lo_slot);
      board.write_reg(CSR_LAST_SLOT, hi_slot);
   endtask

   // One phase: set the range, init, then mostly well-formed adds and pops with
   // targets taken from the used ring, plus some noise.
   task automatic run_phase(slot_type lo_slot, slot_type hi_slot, int n_items,
                            int add_pct, int noise_pct);
      int           done;
      int           pick;
      req_kind_type kind;
      logic         at_head;
      slot_type     tgt;
      settle();
      write_range(lo_slot, hi_slot);
      send_request(REQ_INIT, 1'($urandom_range(0, 1)), slot_type'($urandom_range(0, 255)));
      done = 0;
      while (done < n_items) begin
         at_head = 1'($urandom_range(0, 1));
         tgt     = slot_type'($urandom_range(0, 255));
         board.collect_used();
         if ($urandom_range(0, 99) < noise_pct) begin
            // Noise: stray targets, no-ops and an occasional re-init.
            pick = $urandom_range(0, 9);
            kind = (pick == 0) ? REQ_INIT : (pick < 3) ? REQ_NOP :
                   (pick < 6) ? REQ_POP : REQ_ADD;
         end else begin
            if (!board.free_valid) kind = ($urandom_range(0, 9) == 0) ? REQ_ADD : REQ_POP;
            else if (!board.used_valid) kind = ($urandom_range(0, 9) == 0) ? REQ_POP : REQ_ADD;
            else kind = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_POP;
            if (board.members.size() > 0 && (kind == REQ_POP || !at_head))
               tgt = board.members[$urandom_range(0, board.members.size() - 1)];
         end
         send_request(kind, at_head, tgt);
         if (kind != REQ_NOP) done++;
      end
   endtask

   initial begin : stimulus
      slot_type base;
      board        = new();
      idle_on      = 1'b1;
      hold_request = 0;
      req_valid       <= 1'b0;
      req_type        <= REQ_NOP;
      req_use_head    <= 1'b0;
      req_target_slot <= '0;
      csr_we          <= 1'b0;
      csr_addr        <= CSR_FIRST_SLOT;
      csr_wdata       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Before any init both lists are empty; the first init uses the reset range.
      send_request(REQ_POP, 1'b0, 8'hFF);
      send_request(REQ_ADD, 1'b0, 8'hAA);
      send_request(REQ_NOP, 1'b1, 8'h55);
      send_request(REQ_INIT, 1'b0, 8'h00);
      send_request(REQ_ADD, 1'b0, 8'h80);
      send_request(REQ_ADD, 1'b1, 8'h00);
      send_request(REQ_ADD, 1'b0, board.used_head);
      send_request(REQ_ADD, 1'b0, 8'h00);
      send_request(REQ_POP, 1'b0, board.used_head);
      send_request(REQ_POP, 1'b1, 8'h02);
      send_request(REQ_POP, 1'b0, 8'hFF);

      // Long receiver hold so the block backs up and stops taking requests.
      hold_request = 200;
      repeat (6) send_request(REQ_ADD, 1'($urandom_range(0, 1)), 8'h00);

      // Single-slot pool at the top of the range.
      settle();
      write_range(8'd255, 8'd255);
      send_request(REQ_INIT, 1'b1, 8'hFF);
      send_request(REQ_ADD, 1'b1, 8'h00);
      send_request(REQ_ADD, 1'b0, 8'hFF);
      send_request(REQ_POP, 1'b0, 8'hFF);
      send_request(REQ_POP, 1'b1, 8'hFF);

      // Last slot below first slot leaves the free list empty.
      settle();
      write_range(8'd255, 8'd0);
      send_request(REQ_INIT, 1'b0, 8'h00);
      send_request(REQ_ADD, 1'b1, 8'h7F);
      send_request(REQ_POP, 1'b0, 8'h80);

      // Random phases over several ranges.
      run_phase(8'd0, 8'd255, 260, 92, 4);
      run_phase(8'd0, 8'd255, 150, 50, 12);
      run_phase(8'd0, 8'd0, 30, 50, 10);
      repeat (3) begin
         base = slot_type'($urandom_range(0, 240));
         run_phase(base, base + slot_type'($urandom_range(0, 15)), 60, 55, 10);
      end
      run_phase(8'd200, 8'd3, 20, 50, 20);
      run_phase(slot_type'($urandom_range(0, 255)), slot_type'($urandom_range(0, 255)),
                70, 50, 10);
      idle_on = 1'b0;
      run_phase(8'd0, 8'd255, 100, 55, 8);

      settle();
      repeat (8) @(posedge clock);
      if (board.errors == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

endmodule

/* pooled_linked_list_manager.f */
rtl/pllm_pkg.sv
rtl/pllm_ram.sv
rtl/pllm_engine.sv
rtl/pooled_linked_list_manager.sv
bench/tb.sv
